@@ design/crt_pkg.sv @@
// ----------------------------------------------------------------------------
// crt_pkg
// Types and codes shared by the content registry table and its cells.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int NAME_W = 64;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;

    typedef enum logic [1:0] {
        ACT_LIST       = 2'd0,
        ACT_REGISTER   = 2'd1,
        ACT_SEARCH     = 2'd2,
        ACT_DEREGISTER = 2'd3
    } t_crt_action;

    typedef enum logic [2:0] {
        STS_ACK      = 3'd0,
        STS_FULL     = 3'd1,
        STS_DUP      = 3'd2,
        STS_NOTFOUND = 3'd3,
        STS_EMPTY    = 3'd4,
        STS_LISTED   = 3'd5,
        STS_FOUND    = 3'd6
    } t_crt_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FINISH
    } t_crt_state;

    typedef struct packed {
        logic [NAME_W-1:0] peer;
        logic [NAME_W-1:0] content;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } t_crt_entry;

    // One cell's contents as seen by its neighbor.
    typedef struct packed {
        t_crt_entry entry;
        logic       valid;
        logic       mark;
    } t_crt_slot;

    // Commands broadcast to every cell.
    typedef struct packed {
        logic rotate;
        logic insert;
        logic remove;
        logic mark_clr;
    } t_crt_ctl;

endpackage

@@ design/crt_if.sv @@
// ----------------------------------------------------------------------------
// crt_req_if / crt_rsp_if
// Valid/ready channels carrying registry requests and their results.
// ----------------------------------------------------------------------------
interface crt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] peer_key;
    logic [63:0] content_key;
    logic [31:0] peer_address;
    logic [15:0] peer_port;

    modport source (output valid, action, peer_key, content_key, peer_address,
                    peer_port, input ready);
    modport sink   (input valid, action, peer_key, content_key, peer_address,
                    peer_port, output ready);
endinterface

interface crt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] found_content;
    logic [63:0] found_peer;
    logic [31:0] found_address;
    logic [15:0] found_port;
    logic        last;

    modport source (output valid, status, found_content, found_peer, found_address,
                    found_port, last, input ready);
    modport sink   (input valid, status, found_content, found_peer, found_address,
                    found_port, last, output ready);
endinterface

@@ design/crt_cell.sv @@
// ----------------------------------------------------------------------------
// crt_cell
// One registry slot: holds an entry, compares it against the broadcast key
// and takes its neighbor's contents on rotate or remove, or the new entry on insert.
// ----------------------------------------------------------------------------
module crt_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  crt_pkg::t_crt_ctl               i_ctl,
    input  logic [crt_pkg::NAME_W-1:0]      i_key_peer,
    input  logic [crt_pkg::NAME_W-1:0]      i_key_content,
    input  crt_pkg::t_crt_entry             i_new,
    input  crt_pkg::t_crt_slot              i_next,
    input  logic                            i_prev_valid,
    input  logic                            i_hit,
    output logic                            o_hit,
    output logic                            o_seen,
    output logic                            o_chit,
    output crt_pkg::t_crt_slot              o_slot
);

    crt_pkg::t_crt_entry r_entry, n_entry;
    logic                r_valid, n_valid;
    logic                r_mark,  n_mark;
    logic                w_content_eq;
    logic                w_match;

    assign w_content_eq = (r_entry.content == i_key_content);
    assign w_match      = r_valid && w_content_eq && (r_entry.peer == i_key_peer);

    assign o_hit  = i_hit | w_match;
    assign o_seen = r_valid && r_mark && w_content_eq;
    assign o_chit = r_valid && w_content_eq;
    assign o_slot = '{entry: r_entry, valid: r_valid, mark: r_mark};

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        n_mark  = r_mark;
        if (i_ctl.rotate) begin
            n_entry = i_next.entry;
            n_valid = i_next.valid;
            n_mark  = i_next.mark;
        end else if (i_ctl.remove && o_hit) begin
            // close the gap left by the removed entry
            n_entry = i_next.entry;
            n_valid = i_next.valid;
        end else if (i_ctl.insert && !r_valid && i_prev_valid) begin
            n_entry = i_new;
            n_valid = 1'b1;
        end
        if (i_ctl.mark_clr) begin
            n_mark = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mark  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_mark  <= n_mark;
        end
    end

endmodule

@@ design/content_registry_table.sv @@
// ----------------------------------------------------------------------------
// content_registry_table
// Registry of peer/content entries held in a ring of cells.
// ----------------------------------------------------------------------------
// The table is a ring of CAPACITY cells, one entry per cell, kept packed from
// cell 0 upward in order of registration. Register and deregister requests
// compare the key against every cell at once: the request is accepted, then
// executed with its result handed to the output register once that is free; a
// deregister closes the gap by moving every later cell down one place in the
// same cycle. A list on an empty table is answered in the same way. Other list
// and search requests rotate the ring one place per cycle, unless a list
// holds it for a full output register, for CAPACITY places, so that each entry
// passes cell 0 in order: the request is accepted, the scan marks are cleared,
// the ring turns and the final result is posted, in that order.
// After a full turn the ring is back in its original order. A request can be
// taken while the previous final result still waits in the output register.
// ----------------------------------------------------------------------------
module content_registry_table #(
    parameter int CAPACITY = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crt_req_if.sink     i_req,
    crt_rsp_if.source   o_rsp
);

    localparam int STEP_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    crt_pkg::t_crt_state  r_state, n_state;
    crt_pkg::t_crt_action r_act;
    crt_pkg::t_crt_entry  r_key;
    logic [STEP_W-1:0]    r_step;

    // pending list name / best search match
    logic                 r_res_valid;
    crt_pkg::t_crt_entry  r_res;

    // output register
    logic                 r_out_valid;
    crt_pkg::t_crt_status r_out_status;
    crt_pkg::t_crt_entry  r_out_entry;
    logic                 r_out_last;

    // ring
    crt_pkg::t_crt_slot   w_slot [CAPACITY];
    crt_pkg::t_crt_slot   w_next [CAPACITY];
    logic [CAPACITY:0]    w_hit;
    logic [CAPACITY-1:0]  w_seen;
    logic [CAPACITY-1:0]  w_chit;
    crt_pkg::t_crt_ctl    w_ctl;
    logic [crt_pkg::NAME_W-1:0] w_key_content;

    logic                 w_req_fire;
    logic                 w_out_free;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_any_hit;
    logic                 w_list_new;
    logic                 w_step_ok;
    logic                 w_last_step;

    // output/control decode
    logic                 w_emit;
    crt_pkg::t_crt_status w_emit_status;
    crt_pkg::t_crt_entry  w_emit_entry;
    logic                 w_emit_last;
    logic                 w_res_clr;
    logic                 w_res_load;
    crt_pkg::t_crt_entry  w_res_data;

    assign w_req_fire  = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == crt_pkg::ST_IDLE);
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    assign w_full    = w_slot[CAPACITY-1].valid;
    assign w_empty   = !w_slot[0].valid;
    assign w_any_hit = w_hit[CAPACITY];

    // during a list scan, compare the ring against the name now at the head
    assign w_key_content = (r_state == crt_pkg::ST_SCAN && r_act == crt_pkg::ACT_LIST)
                         ? w_slot[0].entry.content : r_key.content;

    // head name is new when no entry already passed (marked) carries it
    assign w_list_new  = w_slot[0].valid && !(|w_seen);
    // hold the ring while a new name has nowhere to go
    assign w_step_ok   = !(r_act == crt_pkg::ACT_LIST && w_list_new && r_res_valid
                           && !w_out_free);
    assign w_last_step = (r_step == STEP_W'(CAPACITY - 1));

    assign w_hit[0] = 1'b0;

    for (genvar p = 0; p < CAPACITY; p++) begin : g_cell
        logic w_prev_valid;

        if (p == CAPACITY - 1) begin : g_wrap
            // head wraps to the top, marked as already passed
            assign w_next[p] = '{entry: w_slot[0].entry,
                                 valid: w_slot[0].valid & w_ctl.rotate,
                                 mark:  1'b1};
        end else begin : g_link
            assign w_next[p] = w_slot[p+1];
        end

        if (p == 0) begin : g_first
            assign w_prev_valid = 1'b1;
        end else begin : g_rest
            assign w_prev_valid = w_slot[p-1].valid;
        end

        crt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_key_peer    (r_key.peer),
            .i_key_content (w_key_content),
            .i_new         (r_key),
            .i_next        (w_next[p]),
            .i_prev_valid  (w_prev_valid),
            .i_hit         (w_hit[p]),
            .o_hit         (w_hit[p+1]),
            .o_seen        (w_seen[p]),
            .o_chit        (w_chit[p]),
            .o_slot        (w_slot[p])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            crt_pkg::ST_IDLE: begin
                if (w_req_fire) begin
                    n_state = crt_pkg::ST_EXEC;
                end
            end
            crt_pkg::ST_EXEC: begin
                case (r_act)
                    crt_pkg::ACT_LIST: begin
                        if (!w_empty) begin
                            n_state = crt_pkg::ST_SCAN;
                        end else if (w_out_free) begin
                            n_state = crt_pkg::ST_IDLE;
                        end
                    end
                    crt_pkg::ACT_SEARCH: begin
                        n_state = crt_pkg::ST_SCAN;
                    end
                    default: begin
                        if (w_out_free) begin
                            n_state = crt_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            crt_pkg::ST_SCAN: begin
                if (w_step_ok && w_last_step) begin
                    n_state = crt_pkg::ST_FINISH;
                end
            end
            crt_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_state = crt_pkg::ST_IDLE;
                end
            end
            default: n_state = crt_pkg::ST_IDLE;
        endcase
    end

    // ring commands and results
    always_comb begin
        w_ctl         = '0;
        w_emit        = 1'b0;
        w_emit_status = crt_pkg::STS_ACK;
        w_emit_entry  = '0;
        w_emit_last   = 1'b1;
        w_res_clr     = 1'b0;
        w_res_load    = 1'b0;
        w_res_data    = w_slot[0].entry;
        case (r_state)
            crt_pkg::ST_EXEC: begin
                case (r_act)
                    crt_pkg::ACT_LIST: begin
                        if (w_empty) begin
                            w_emit        = w_out_free;
                            w_emit_status = crt_pkg::STS_EMPTY;
                        end else begin
                            w_ctl.mark_clr = 1'b1;
                            w_res_clr      = 1'b1;
                        end
                    end
                    crt_pkg::ACT_SEARCH: begin
                        w_ctl.mark_clr = 1'b1;
                        w_res_clr      = 1'b1;
                    end
                    crt_pkg::ACT_REGISTER: begin
                        if (w_out_free) begin
                            w_emit = 1'b1;
                            if (w_full) begin
                                w_emit_status = crt_pkg::STS_FULL;
                            end else if (w_any_hit) begin
                                w_emit_status = crt_pkg::STS_DUP;
                            end else begin
                                w_emit_status = crt_pkg::STS_ACK;
                                w_ctl.insert  = 1'b1;
                            end
                        end
                    end
                    crt_pkg::ACT_DEREGISTER: begin
                        if (w_out_free) begin
                            w_emit        = 1'b1;
                            w_emit_status = w_any_hit ? crt_pkg::STS_ACK
                                                      : crt_pkg::STS_NOTFOUND;
                            w_ctl.remove  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            crt_pkg::ST_SCAN: begin
                if (w_step_ok) begin
                    w_ctl.rotate = 1'b1;
                    if (r_act == crt_pkg::ACT_LIST) begin
                        if (w_list_new) begin
                            // flush the previous name, keep the new one pending
                            w_res_load = 1'b1;
                            if (r_res_valid) begin
                                w_emit                = 1'b1;
                                w_emit_status         = crt_pkg::STS_LISTED;
                                w_emit_entry.content  = r_res.content;
                                w_emit_last           = 1'b0;
                            end
                        end
                    end else if (w_chit[0]) begin
                        // later entries overwrite: newest match wins
                        w_res_load = 1'b1;
                    end
                end
            end
            crt_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (r_act == crt_pkg::ACT_LIST) begin
                        w_emit_status        = crt_pkg::STS_LISTED;
                        w_emit_entry.content = r_res.content;
                    end else if (r_res_valid) begin
                        w_emit_status = crt_pkg::STS_FOUND;
                        w_emit_entry  = r_res;
                    end else begin
                        w_emit_status = crt_pkg::STS_NOTFOUND;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_req_fire) begin
            r_act         <= crt_pkg::t_crt_action'(i_req.action);
            r_key.peer    <= i_req.peer_key;
            r_key.content <= i_req.content_key;
            r_key.addr    <= i_req.peer_address;
            r_key.port    <= i_req.peer_port;
        end
        if (w_res_load) begin
            r_res <= w_res_data;
        end
        if (w_emit) begin
            r_out_status <= w_emit_status;
            r_out_entry  <= w_emit_entry;
            r_out_last   <= w_emit_last;
        end
        if (!i_rst_n) begin
            r_state     <= crt_pkg::ST_IDLE;
            r_step      <= '0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.mark_clr) begin
                r_step <= '0;
            end else if (w_ctl.rotate) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (w_res_clr) begin
                r_res_valid <= 1'b0;
            end else if (w_res_load) begin
                r_res_valid <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.found_content = r_out_entry.content;
    assign o_rsp.found_peer    = r_out_entry.peer;
    assign o_rsp.found_address = r_out_entry.addr;
    assign o_rsp.found_port    = r_out_entry.port;
    assign o_rsp.last          = r_out_last;

endmodule

@@ design/crt_checker.sv @@
// ----------------------------------------------------------------------------
// crt_checker
// Port-level checks of the content registry table, bound to its top level.
// ----------------------------------------------------------------------------
module crt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [2:0]  i_rsp_status,
    input logic [63:0] i_rsp_peer,
    input logic [31:0] i_rsp_address,
    input logic [15:0] i_rsp_port,
    input logic        i_rsp_last
);

    // the block is not ready again in the cycle after a taken request
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted back to back");

    // only listed names may be followed by more results
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != crt_pkg::STS_LISTED |-> i_rsp_last)
        else $error("non-list result without last");

    // peer, address and port are only reported for a found entry
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != crt_pkg::STS_FOUND
        |-> i_rsp_peer == '0 && i_rsp_address == '0 && i_rsp_port == '0)
        else $error("entry fields set on a non-found result");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready
        |=> i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_last))
        else $error("result dropped or changed while stalled");

endmodule

bind content_registry_table crt_checker u_crt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_peer    (o_rsp.found_peer),
    .i_rsp_address (o_rsp.found_address),
    .i_rsp_port    (o_rsp.found_port),
    .i_rsp_last    (o_rsp.last)
);
